### hdl/arm_pkg.sv
package arm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int OUT_W = 17;
   localparam int PHASE_W = 20;
   localparam int VOL_W = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int MAX_RUN = 64;
   localparam int RUN_W = 7;
   localparam int OUT_MAX = 65535;
   localparam int OUT_MIN = -65536;

   localparam logic [PHASE_W-1:0] STEP_RST = PHASE_W'(8192);
   localparam logic [VOL_W-1:0] VOL_RST = VOL_W'(256);

   typedef enum logic [1:0] {
      MODE_FLAT    = 2'd0,
      MODE_NEAREST = 2'd1,
      MODE_LINEAR  = 2'd2,
      MODE_CUBIC   = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_STEREO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_STEREO = 3'd4;

endpackage

### hdl/arm_req_if.sv
interface arm_req_if;
   logic valid;
   logic ready;
   logic signed [arm_pkg::SAMPLE_W-1:0] sample_left;
   logic signed [arm_pkg::SAMPLE_W-1:0] sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

### hdl/arm_rsp_if.sv
interface arm_rsp_if;
   logic valid;
   logic ready;
   logic signed [arm_pkg::OUT_W-1:0] out_left;
   logic signed [arm_pkg::OUT_W-1:0] out_right;
   logic last_of_run;

   modport source (output valid, output out_left, output out_right, output last_of_run,
                   input ready);
   modport sink (input valid, input out_left, input out_right, input last_of_run,
                 output ready);
endinterface

### hdl/audio_resampling_mixer.sv
// Fractional-phase audio resampler with nearest, linear or cubic Hermite
// interpolation, volume and mono/stereo mapping. Each request is one source
// frame; it produces zero to 64 output frames (flat mode: exactly one). All
// multiplies by the phase fraction or the volume run through one shared
// multiply-shift-add unit, one product per cycle. Per channel an output frame
// steps through S_STEP1, S_SCL, S_SAVE (nearest, linear) or S_STEP1, S_CUB2,
// S_CUB3, S_SCL, S_SAVE (cubic), then through the formatting S_FORM, the
// handoff S_OUT, where it waits until taken, and the loop check S_CHK; a
// request is accepted in S_IDLE, advances its phase in S_ADV and ends in a
// final S_CHK; flat mode skips the loop check. The block takes no new request
// until every output of the current one has been taken.
module audio_resampling_mixer #(
   parameter int FRAC_BITS = 13
) (
   input  logic clock,
   input  logic reset,
   arm_req_if.sink req_ch,
   arm_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic [arm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [arm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int W = FRAC_BITS + 22;
   localparam int BW = ((FRAC_BITS > 9) ? FRAC_BITS : 9) + 1;
   localparam int PW_ = arm_pkg::PHASE_W;
   localparam logic [PW_-1:0] PHASE_ONE = PW_'(1) << FRAC_BITS;
   localparam logic [PW_-1:0] PHASE_RST = PW_'(3) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_ADV, S_CHK, S_STEP1, S_CUB2, S_CUB3, S_SCL, S_SAVE, S_FORM, S_OUT
   } state_type;

   state_type state_ff;
   arm_pkg::mode_type mode_ff;
   logic [PW_-1:0] step_ff;
   logic [arm_pkg::VOL_W-1:0] vol_ff;
   logic src_st_ff;
   logic out_st_ff;
   logic signed [arm_pkg::SAMPLE_W-1:0] win_ff [4][2];
   logic [PW_-1:0] phase_ff;
   logic [arm_pkg::RUN_W-1:0] cnt_ff;
   logic ch_ff;
   logic signed [W-1:0] sc_ff [2];
   logic signed [arm_pkg::OUT_W-1:0] left_ff;
   logic signed [arm_pkg::OUT_W-1:0] right_ff;
   logic last_ff;

   logic signed [arm_pkg::SAMPLE_W-1:0] p0, p1, p2, p3;
   logic signed [20:0] ca, cb, cc;
   logic signed [16:0] diff;
   logic signed [W-1:0] coef_a, coef_b, coef_c, s1_w, y_val;
   logic signed [W-1:0] op_a, addend, alu_res;
   logic signed [BW-1:0] op_b;
   logic frac_shift;
   logic [PW_:0] phase_sum;
   logic [PW_-1:0] phase_next;
   logic signed [W:0] mix_l, mix_r;
   logic signed [arm_pkg::OUT_W-1:0] sat_l, sat_r;

   assign p0 = win_ff[0][ch_ff];
   assign p1 = win_ff[1][ch_ff];
   assign p2 = win_ff[2][ch_ff];
   assign p3 = win_ff[3][ch_ff];

   assign ca = 21'sd3 * (21'(p1) - 21'(p2)) - 21'(p0) + 21'(p3);
   assign cb = 21'sd4 * 21'(p2) + 21'sd2 * 21'(p0) - 21'sd5 * 21'(p1) - 21'(p3);
   assign cc = 21'(p2) - 21'(p0);
   assign diff = 17'(p2) - 17'(p1);

   assign coef_a = W'(ca) <<< (FRAC_BITS - 1);
   assign coef_b = W'(cb) <<< (FRAC_BITS - 1);
   assign coef_c = W'(cc) <<< (FRAC_BITS - 1);
   assign s1_w = W'(p1) <<< FRAC_BITS;

   always_comb begin
      unique case (mode_ff)
         arm_pkg::MODE_CUBIC: y_val = alu_res >>> FRAC_BITS;
         arm_pkg::MODE_LINEAR: y_val = alu_res;
         default: y_val = W'(p1);
      endcase
   end

   always_comb begin
      op_a = '0;
      op_b = BW'({1'b0, phase_ff[FRAC_BITS-1:0]});
      frac_shift = 1'b1;
      addend = '0;
      unique case (state_ff)
         S_STEP1: begin
            if (mode_ff == arm_pkg::MODE_CUBIC) begin
               op_a = coef_a;
               addend = coef_b;
            end else begin
               op_a = W'(diff);
               addend = W'(p1);
            end
         end
         S_CUB2: begin
            op_a = alu_res;
            addend = coef_c;
         end
         S_CUB3: begin
            op_a = alu_res;
            addend = s1_w;
         end
         S_SCL: begin
            op_a = y_val;
            op_b = BW'({1'b0, vol_ff});
            frac_shift = 1'b0;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   arm_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock(clock),
      .op_a(op_a),
      .op_b(op_b),
      .frac_shift(frac_shift),
      .addend(addend),
      .result(alu_res)
   );

   assign phase_sum = (PW_+1)'(phase_ff) + (PW_+1)'(step_ff);
   assign phase_next = phase_sum[PW_] ? {PW_{1'b1}} : phase_sum[PW_-1:0];

   always_comb begin
      if (src_st_ff && out_st_ff) begin
         mix_l = (W+1)'(sc_ff[0]);
         mix_r = (W+1)'(sc_ff[1]);
      end else if (out_st_ff) begin
         mix_l = (W+1)'(sc_ff[0]);
         mix_r = (W+1)'(sc_ff[0]);
      end else if (src_st_ff) begin
         mix_l = ((W+1)'(sc_ff[0]) + (W+1)'(sc_ff[1])) >>> 1;
         mix_r = '0;
      end else begin
         mix_l = (W+1)'(sc_ff[0]);
         mix_r = '0;
      end
   end

   always_comb begin
      if (mix_l > (W+1)'(arm_pkg::OUT_MAX)) sat_l = arm_pkg::OUT_W'(arm_pkg::OUT_MAX);
      else if (mix_l < (W+1)'(arm_pkg::OUT_MIN)) sat_l = arm_pkg::OUT_W'(arm_pkg::OUT_MIN);
      else sat_l = arm_pkg::OUT_W'(mix_l);
      if (mix_r > (W+1)'(arm_pkg::OUT_MAX)) sat_r = arm_pkg::OUT_W'(arm_pkg::OUT_MAX);
      else if (mix_r < (W+1)'(arm_pkg::OUT_MIN)) sat_r = arm_pkg::OUT_W'(arm_pkg::OUT_MIN);
      else sat_r = arm_pkg::OUT_W'(mix_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= arm_pkg::MODE_FLAT;
         step_ff <= arm_pkg::STEP_RST;
         vol_ff <= arm_pkg::VOL_RST;
         src_st_ff <= 1'b1;
         out_st_ff <= 1'b1;
         phase_ff <= PHASE_RST;
         cnt_ff <= '0;
         ch_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            win_ff[k][0] <= '0;
            win_ff[k][1] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               arm_pkg::CSR_MODE: mode_ff <= arm_pkg::mode_type'(csr_wdata[1:0]);
               arm_pkg::CSR_STEP: step_ff <= csr_wdata[PW_-1:0];
               arm_pkg::CSR_VOLUME: vol_ff <= csr_wdata[arm_pkg::VOL_W-1:0];
               arm_pkg::CSR_SRC_STEREO: src_st_ff <= csr_wdata[0];
               arm_pkg::CSR_OUT_STEREO: out_st_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  for (int k = 0; k < 3; k++) begin
                     win_ff[k][0] <= win_ff[k+1][0];
                     win_ff[k][1] <= win_ff[k+1][1];
                  end
                  win_ff[3][0] <= req_ch.sample_left;
                  win_ff[3][1] <= req_ch.sample_right;
                  state_ff <= S_ADV;
               end
            end
            S_ADV: begin
               cnt_ff <= '0;
               ch_ff <= 1'b0;
               if (mode_ff == arm_pkg::MODE_FLAT) begin
                  state_ff <= S_STEP1;
               end else begin
                  if (phase_ff >= PHASE_ONE) phase_ff <= phase_ff - PHASE_ONE;
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               ch_ff <= 1'b0;
               if (phase_ff < PHASE_ONE && cnt_ff < arm_pkg::RUN_W'(arm_pkg::MAX_RUN)) begin
                  state_ff <= S_STEP1;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_STEP1: begin
               state_ff <= (mode_ff == arm_pkg::MODE_CUBIC) ? S_CUB2 : S_SCL;
            end
            S_CUB2: state_ff <= S_CUB3;
            S_CUB3: state_ff <= S_SCL;
            S_SCL: state_ff <= S_SAVE;
            S_SAVE: begin
               sc_ff[ch_ff] <= alu_res;
               if (!ch_ff && src_st_ff) begin
                  ch_ff <= 1'b1;
                  state_ff <= S_STEP1;
               end else begin
                  state_ff <= S_FORM;
               end
            end
            S_FORM: begin
               left_ff <= sat_l;
               right_ff <= sat_r;
               last_ff <= (mode_ff == arm_pkg::MODE_FLAT) || (phase_next >= PHASE_ONE)
                          || (cnt_ff == arm_pkg::RUN_W'(arm_pkg::MAX_RUN - 1));
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ch.ready) begin
                  if (mode_ff == arm_pkg::MODE_FLAT) begin
                     state_ff <= S_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                     phase_ff <= phase_next;
                     state_ff <= S_CHK;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_OUT);
   assign rsp_ch.out_left = left_ff;
   assign rsp_ch.out_right = right_ff;
   assign rsp_ch.last_of_run = last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("request taken while a result is pending");

   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= arm_pkg::RUN_W'(arm_pkg::MAX_RUN))
      else $error("run count beyond cap");

   a_phase_reset: assert property (@(posedge clock)
      $past(reset) |-> phase_ff == PHASE_RST)
      else $error("phase not at startup value after reset");

   a_mono_right: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !out_st_ff |-> rsp_ch.out_right == '0)
      else $error("mono output carries a right channel");

   a_flat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && mode_ff == arm_pkg::MODE_FLAT |-> rsp_ch.last_of_run)
      else $error("flat output not marked last");

endmodule

### hdl/arm_mac.sv
module arm_mac #(
   parameter int FRAC_BITS = 13
) (
   input  logic clock,
   input  logic signed [FRAC_BITS+21:0] op_a,
   input  logic signed [((FRAC_BITS > 9) ? FRAC_BITS : 9):0] op_b,
   input  logic frac_shift,
   input  logic signed [FRAC_BITS+21:0] addend,
   output logic signed [FRAC_BITS+21:0] result
);

   localparam int W = FRAC_BITS + 22;
   localparam int BW = ((FRAC_BITS > 9) ? FRAC_BITS : 9) + 1;
   localparam int PW = W + BW;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] shifted;
   logic signed [W-1:0] res_in;
   logic signed [W-1:0] res_ff;

   assign prod = PW'(op_a) * PW'(op_b);
   assign shifted = frac_shift ? (prod >>> FRAC_BITS) : (prod >>> 8);
   assign res_in = W'(shifted) + addend;

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

### tb/tb_audio_resampling_mixer.sv
module tb_audio_resampling_mixer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 13;
   localparam int ONE = 1 << FRAC;
   localparam int unsigned PHASE_SAT = 32'hFFFFF;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 40;
   localparam logic [arm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [arm_pkg::OUT_W-1:0] left;
      logic signed [arm_pkg::OUT_W-1:0] right;
      logic last;
   } out_frame_type;

   class resampler_scoreboard;
      arm_pkg::mode_type mode;
      int unsigned step;
      int unsigned vol;
      bit src_st;
      bit out_st;
      longint win[8];
      int unsigned phase;
      out_frame_type frames_due[$];
      int mismatches;

      function new();
         mode = arm_pkg::MODE_FLAT;
         step = 8192;
         vol = 256;
         src_st = 1;
         out_st = 1;
         foreach (win[i]) win[i] = 0;
         phase = 3 * ONE;
         mismatches = 0;
      endfunction

      function void write_reg(logic [arm_pkg::CSR_IDX_W-1:0] idx,
                              logic [arm_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            arm_pkg::CSR_MODE: mode = arm_pkg::mode_type'(val[1:0]);
            arm_pkg::CSR_STEP: step = 32'(val);
            arm_pkg::CSR_VOLUME: vol = 32'(val[arm_pkg::VOL_W-1:0]);
            arm_pkg::CSR_SRC_STEREO: src_st = val[0];
            arm_pkg::CSR_OUT_STEREO: out_st = val[0];
            default: ;
         endcase
      endfunction

      function longint interpolate(int ch, longint frac);
         longint p0, p1, p2, p3, s0, s1, s2, s3, a, b, c;
         p0 = win[ch];
         p1 = win[2 + ch];
         p2 = win[4 + ch];
         p3 = win[6 + ch];
         if (mode == arm_pkg::MODE_NEAREST) return p1;
         if (mode == arm_pkg::MODE_LINEAR) return p1 + (((p2 - p1) * frac) >>> FRAC);
         s0 = p0 <<< FRAC;
         s1 = p1 <<< FRAC;
         s2 = p2 <<< FRAC;
         s3 = p3 <<< FRAC;
         a = (3 * (s1 - s2) - s0 + s3) / 2;
         b = 2 * s2 + s0 - ((5 * s1 + s3) / 2);
         c = (s2 - s0) / 2;
         a = ((a * frac) >>> FRAC) + b;
         a = ((a * frac) >>> FRAC) + c;
         a = ((a * frac) >>> FRAC) + s1;
         return a >>> FRAC;
      endfunction

      function longint gain(longint x);
         return (x * longint'(vol)) >>> 8;
      endfunction

      function logic signed [arm_pkg::OUT_W-1:0] clamp(longint v);
         if (v > arm_pkg::OUT_MAX) v = arm_pkg::OUT_MAX;
         if (v < arm_pkg::OUT_MIN) v = arm_pkg::OUT_MIN;
         return v[arm_pkg::OUT_W-1:0];
      endfunction

      function out_frame_type mix_frame(longint frac);
         longint l, r;
         out_frame_type f;
         if (src_st && out_st) begin
            l = gain(interpolate(0, frac));
            r = gain(interpolate(1, frac));
         end else if (!src_st && out_st) begin
            l = gain(interpolate(0, frac));
            r = l;
         end else if (src_st) begin
            l = (gain(interpolate(0, frac)) + gain(interpolate(1, frac))) >>> 1;
            r = 0;
         end else begin
            l = gain(interpolate(0, frac));
            r = 0;
         end
         f.left = clamp(l);
         f.right = clamp(r);
         f.last = 0;
         return f;
      endfunction

      function void note_request(logic signed [arm_pkg::SAMPLE_W-1:0] sl,
                                 logic signed [arm_pkg::SAMPLE_W-1:0] sr);
         out_frame_type f;
         int n;
         int unsigned nxt;
         for (int i = 0; i < 6; i++) win[i] = win[i + 2];
         win[6] = sl;
         win[7] = sr;
         if (mode == arm_pkg::MODE_FLAT) begin
            f = mix_frame(0);
            f.last = 1;
            frames_due.push_back(f);
            return;
         end
         n = 0;
         if (phase >= ONE) phase -= ONE;
         while (phase < ONE && n < arm_pkg::MAX_RUN) begin
            f = mix_frame(phase);
            frames_due.push_back(f);
            n++;
            nxt = phase + step;
            phase = (nxt > PHASE_SAT) ? PHASE_SAT : nxt;
         end
         if (n > 0) frames_due[$].last = 1;
      endfunction

      function void fail_note(string what, longint exp_v, longint act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
      endfunction

      function void check_result(out_frame_type got);
         out_frame_type want;
         if (frames_due.size() == 0) begin
            fail_note("unexpected output, left", 0, got.left);
            return;
         end
         want = frames_due.pop_front();
         if (got.left !== want.left) fail_note("out_left", want.left, got.left);
         if (got.right !== want.right) fail_note("out_right", want.right, got.right);
         if (got.last !== want.last) fail_note("last_of_run", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [arm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [arm_pkg::CSR_DATA_W-1:0] csr_wdata;
   bit req_no_gaps;
   bit rsp_no_stalls;
   int cycles;

   arm_req_if req_ch();
   arm_rsp_if rsp_ch();

   resampler_scoreboard sb = new();

   audio_resampling_mixer dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      out_frame_type got;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("audio_resampling_mixer regression: fail");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.left = rsp_ch.out_left;
         got.right = rsp_ch.out_right;
         got.last = rsp_ch.last_of_run;
         sb.check_result(got);
      end
   end

   initial begin
      int n;
      rsp_ch.ready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = rsp_no_stalls ? 0 : $urandom_range(0, 13);
         if (n > 0) begin
            rsp_ch.ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic send_frame(logic signed [arm_pkg::SAMPLE_W-1:0] sl,
                             logic signed [arm_pkg::SAMPLE_W-1:0] sr);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.sample_left <= sl;
      req_ch.sample_right <= sr;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(sl, sr);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [arm_pkg::CSR_IDX_W-1:0] idx,
                            logic [arm_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic setup(arm_pkg::mode_type m, int unsigned stp, int unsigned v, bit ss, bit os);
      drain();
      write_csr(arm_pkg::CSR_MODE, arm_pkg::CSR_DATA_W'(m));
      write_csr(arm_pkg::CSR_STEP, arm_pkg::CSR_DATA_W'(stp));
      write_csr(arm_pkg::CSR_VOLUME, arm_pkg::CSR_DATA_W'(v));
      write_csr(arm_pkg::CSR_SRC_STEREO, arm_pkg::CSR_DATA_W'(ss));
      write_csr(arm_pkg::CSR_OUT_STEREO, arm_pkg::CSR_DATA_W'(os));
   endtask

   task automatic send_random();
      send_frame(arm_pkg::SAMPLE_W'($urandom), arm_pkg::SAMPLE_W'($urandom));
   endtask

   function automatic int unsigned pick_step();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 128;
         2: return 524288;
         3: return 20'hFFFFF;
         4: return $urandom_range(128, 2048);
         default: return $urandom_range(2048, 20000);
      endcase
   endfunction

   function automatic int unsigned pick_volume();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 256;
         2: return 511;
         default: return $urandom_range(0, 511);
      endcase
   endfunction

   initial begin
      cycles = 0;
      reset <= 1;
      csr_we <= 0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 0;
      req_ch.sample_left <= '0;
      req_ch.sample_right <= '0;
      req_no_gaps = 0;
      rsp_no_stalls = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_frame(16'sh7FFF, -16'sh8000);
      send_frame(-16'sh8000, 16'sh7FFF);
      send_frame(16'sh0000, 16'sh0001);
      setup(arm_pkg::MODE_CUBIC, 4096, 511, 1, 1);
      send_frame(16'sh7FFF, 16'sh7FFF);
      send_frame(-16'sh8000, -16'sh8000);
      send_frame(16'sh7FFF, 16'sh7FFF);
      send_frame(-16'sh8000, -16'sh8000);
      setup(arm_pkg::MODE_NEAREST, 0, 256, 0, 1);
      send_frame(16'sh1234, -16'sh4321);
      send_frame(-16'sh0001, 16'sh7FFF);
      setup(arm_pkg::MODE_LINEAR, 128, 0, 1, 0);
      send_frame(16'sh7FFF, 16'sh7FFF);
      setup(arm_pkg::MODE_LINEAR, 12000, 300, 1, 0);
      send_frame(-16'sh8000, -16'sh8000);
      send_frame(16'sh7FFF, -16'sh8000);
      setup(arm_pkg::MODE_CUBIC, 20'hFFFFF, 256, 0, 0);
      send_frame(16'sh4000, 16'sh0000);
      send_frame(-16'sh4000, 16'sh0000);
      send_frame(16'sh0100, 16'sh0000);
      setup(arm_pkg::MODE_CUBIC, 524288, 200, 1, 1);
      write_csr(CSR_UNUSED, 20'hABCDE);
      send_frame(16'sh1111, 16'sh2222);
      send_frame(16'sh3333, -16'sh4444);

      for (int ph = 0; ph < 9; ph++) begin
         setup(arm_pkg::mode_type'($urandom_range(0, 3)), pick_step(), pick_volume(),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         req_no_gaps = (ph % 3 == 1);
         rsp_no_stalls = (ph % 4 == 2);
         for (int k = 0; k < 20; k++) begin
            if (ph == 3 && k == 10) drain();
            send_random();
         end
      end
      req_no_gaps = 0;
      rsp_no_stalls = 0;
      drain();

      if (sb.mismatches == 0 && sb.frames_due.size() == 0)
         $display("audio_resampling_mixer regression: pass");
      else
         $display("audio_resampling_mixer regression: fail");
      $finish;
   end
endmodule

### filelist.f
hdl/arm_pkg.sv
hdl/arm_req_if.sv
hdl/arm_rsp_if.sv
hdl/arm_mac.sv
hdl/audio_resampling_mixer.sv
tb/tb_audio_resampling_mixer.sv
